// ===== rtl/epoch_to_calendar_breakdown_top_defines.svh =====
// ============================================================================
// Epoch to calendar breakdown: assertion macros
// Shared macros for the concurrent checks on the converter's ports.
// ============================================================================
`ifndef EPOCH_TO_CALENDAR_BREAKDOWN_TOP_DEFINES_SVH
`define EPOCH_TO_CALENDAR_BREAKDOWN_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ECTC_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ECTC_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ectc_pkg.sv =====
// ============================================================================
// Epoch to calendar breakdown: package
// Constants, pipeline control type and the month table shared by the units.
// ============================================================================
`default_nettype none

package ectc_pkg;

  localparam int unsigned NUM_STAGES = 7;
  localparam int unsigned ADDR_W     = 3;

  typedef struct packed {
    logic [NUM_STAGES-1:0] load;
  } ectc_ctrl_t;

  localparam logic [ADDR_W-3:0] REG_MIN_VALID_EPOCH = 1'b0;
  localparam logic [31:0]       MIN_VALID_RESET     = 32'd1577836800;

  // Reciprocals for division by constants; each estimate is low by at most one.
  localparam logic [31:0] DAY_RECIP  = 32'd3257812230;  // 2^48 / 86400
  localparam logic [10:0] HOUR_RECIP = 11'd1165;        // 2^22 / 3600
  localparam logic [10:0] MIN_RECIP  = 11'd1092;        // 2^16 / 60
  localparam logic [16:0] WEEK_RECIP = 17'd74898;       // 2^19 / 7
  localparam logic [15:0] QUAD_RECIP = 16'd45933;       // 2^26 / 1461

  localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
  localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
  localparam logic [5:0]  SECS_PER_MIN  = 6'd60;
  localparam logic [2:0]  DAYS_PER_WEEK = 3'd7;
  localparam logic [2:0]  WEEKDAY_AT_ORIGIN = 3'd4;
  localparam logic [10:0] DAYS_PER_QUAD = 11'd1461;
  localparam logic [8:0]  DAYS_LEAP_YEAR = 9'd366;
  localparam logic [8:0]  DAYS_YEAR      = 9'd365;

  // Days are counted from 1968-01-01, the start of a four-year block.
  localparam logic [9:0]  QUAD_ORIGIN_SHIFT = 10'd731;
  // 2100-03-01 as days since 1970; a phantom 29 February is inserted before it.
  localparam logic [15:0] DAY_MAR_2100 = 16'd47541;
  localparam logic [5:0]  QUAD_2100    = 6'd33;
  localparam logic [7:0]  QUAD_YEAR_BIAS = 8'd32;

  function automatic logic [8:0] month_start(input logic [3:0] idx, input logic leap);
    logic [8:0] base;
    base = 9'd0;
    case (idx)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd59;
      4'd3:    base = 9'd90;
      4'd4:    base = 9'd120;
      4'd5:    base = 9'd151;
      4'd6:    base = 9'd181;
      4'd7:    base = 9'd212;
      4'd8:    base = 9'd243;
      4'd9:    base = 9'd273;
      4'd10:   base = 9'd304;
      4'd11:   base = 9'd334;
      default: base = 9'd0;
    endcase
    if (leap && (idx >= 4'd2)) begin
      base = base + 9'd1;
    end
    return base;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/ectc_pipe_ctrl.sv =====
// ============================================================================
// Epoch to calendar breakdown: pipeline control
// Valid bits per stage and the load enables that let bubbles close up.
// ============================================================================
`default_nettype none

module ectc_pipe_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output ectc_pkg::ectc_ctrl_t    ctrl
);
  import ectc_pkg::*;

  logic [NUM_STAGES-1:0] vld;
  logic [NUM_STAGES-1:0] ready;

  always_comb begin
    ready[NUM_STAGES-1] = !vld[NUM_STAGES-1] || !out_stall;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      ready[k] = !vld[k] || ready[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (ready[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (ready[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign in_stall  = !ready[0];
  assign out_valid = vld[NUM_STAGES-1];
  assign ctrl.load = ready;

endmodule

`default_nettype wire

// ===== rtl/ectc_tod.sv =====
// ============================================================================
// Epoch to calendar breakdown: time-of-day unit
// Splits the epoch into whole days, hour, minute and second, and compares it
// against the validity threshold.
// ============================================================================
`default_nettype none

module ectc_tod (
  input  wire logic                 clk,
  input  wire ectc_pkg::ectc_ctrl_t ctrl,
  input  wire logic [31:0]          epoch_seconds,
  input  wire logic [31:0]          min_valid_epoch,
  output logic [15:0]               days,
  output logic [5:0]                second,
  output logic [5:0]                minute,
  output logic [4:0]                hour,
  output logic                      valid_res
);
  import ectc_pkg::*;

  logic [63:0] day_prod;
  logic [31:0] s1_epoch;
  logic [15:0] s1_day_est;
  logic        s1_valid;

  logic [32:0] day_rem_full;
  logic [17:0] day_rem;
  logic [15:0] days_next;
  logic [16:0] sod_next;
  logic [16:0] s2_sod;
  logic        s2_valid;

  logic [27:0] hour_prod;
  logic [16:0] s3_sod;
  logic [4:0]  s3_hour_est;
  logic        s3_valid;

  logic [16:0] hour_rem_full;
  logic [12:0] hour_rem;
  logic [4:0]  hour_next;
  logic [11:0] soh_next;
  logic [4:0]  s4_hour;
  logic [11:0] s4_soh;
  logic        s4_valid;

  logic [22:0] min_prod;
  logic [4:0]  s5_hour;
  logic [11:0] s5_soh;
  logic [5:0]  s5_min_est;
  logic        s5_valid;

  logic [11:0] min_rem_full;
  logic [6:0]  min_rem;
  logic [5:0]  minute_next;
  logic [5:0]  second_next;
  logic [4:0]  s6_hour;
  logic [5:0]  s6_minute;
  logic [5:0]  s6_second;
  logic        s6_valid;

  // Stage 1: day estimate by reciprocal multiplication.
  assign day_prod = 64'(epoch_seconds) * 64'(DAY_RECIP);

  always_ff @(posedge clk) begin
    if (ctrl.load[0]) begin
      s1_epoch   <= epoch_seconds;
      s1_day_est <= day_prod[63:48];
      s1_valid   <= epoch_seconds > min_valid_epoch;
    end
  end

  // Stage 2: remainder and correction give days and seconds of the day.
  assign day_rem_full = {1'b0, s1_epoch} - 33'(s1_day_est) * 33'(SECS_PER_DAY);
  assign day_rem      = day_rem_full[17:0];

  always_comb begin
    if (day_rem >= 18'(SECS_PER_DAY)) begin
      days_next = s1_day_est + 16'd1;
      sod_next  = 17'(day_rem - 18'(SECS_PER_DAY));
    end else begin
      days_next = s1_day_est;
      sod_next  = day_rem[16:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[1]) begin
      days     <= days_next;
      s2_sod   <= sod_next;
      s2_valid <= s1_valid;
    end
  end

  // Stage 3: hour estimate.
  assign hour_prod = 28'(s2_sod) * 28'(HOUR_RECIP);

  always_ff @(posedge clk) begin
    if (ctrl.load[2]) begin
      s3_sod      <= s2_sod;
      s3_hour_est <= hour_prod[26:22];
      s3_valid    <= s2_valid;
    end
  end

  // Stage 4: hour correction and seconds within the hour.
  assign hour_rem_full = s3_sod - 17'(s3_hour_est) * 17'(SECS_PER_HOUR);
  assign hour_rem      = hour_rem_full[12:0];

  always_comb begin
    if (hour_rem >= 13'(SECS_PER_HOUR)) begin
      hour_next = s3_hour_est + 5'd1;
      soh_next  = 12'(hour_rem - 13'(SECS_PER_HOUR));
    end else begin
      hour_next = s3_hour_est;
      soh_next  = hour_rem[11:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[3]) begin
      s4_hour  <= hour_next;
      s4_soh   <= soh_next;
      s4_valid <= s3_valid;
    end
  end

  // Stage 5: minute estimate.
  assign min_prod = 23'(s4_soh) * 23'(MIN_RECIP);

  always_ff @(posedge clk) begin
    if (ctrl.load[4]) begin
      s5_hour    <= s4_hour;
      s5_soh     <= s4_soh;
      s5_min_est <= min_prod[21:16];
      s5_valid   <= s4_valid;
    end
  end

  // Stage 6: minute correction and seconds.
  assign min_rem_full = s5_soh - 12'(s5_min_est) * 12'(SECS_PER_MIN);
  assign min_rem      = min_rem_full[6:0];

  always_comb begin
    if (min_rem >= 7'(SECS_PER_MIN)) begin
      minute_next = s5_min_est + 6'd1;
      second_next = 6'(min_rem - 7'(SECS_PER_MIN));
    end else begin
      minute_next = s5_min_est;
      second_next = min_rem[5:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[5]) begin
      s6_hour   <= s5_hour;
      s6_minute <= minute_next;
      s6_second <= second_next;
      s6_valid  <= s5_valid;
    end
  end

  // Stage 7: output register.
  always_ff @(posedge clk) begin
    if (ctrl.load[6]) begin
      hour      <= s6_hour;
      minute    <= s6_minute;
      second    <= s6_second;
      valid_res <= s6_valid;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ectc_date.sv =====
// ============================================================================
// Epoch to calendar breakdown: date unit
// Turns whole days since 1970 into weekday, year, day of year, month and day
// of month using four-year blocks counted from 1968.
// ============================================================================
`default_nettype none

module ectc_date (
  input  wire logic                 clk,
  input  wire ectc_pkg::ectc_ctrl_t ctrl,
  input  wire logic [15:0]          days,
  output logic [15:0]               days_since_1970,
  output logic [2:0]                weekday,
  output logic signed [7:0]         year_from_2000,
  output logic [8:0]                day_in_year,
  output logic [3:0]                month,
  output logic [4:0]                day_in_month
);
  import ectc_pkg::*;

  logic        corr;
  logic [15:0] shifted;
  logic [15:0] wk;
  logic [31:0] wk_prod;
  logic [31:0] quad_prod;
  logic [15:0] s3_days;
  logic [15:0] s3_wk;
  logic [12:0] s3_wk_est;
  logic [15:0] s3_shift;
  logic [5:0]  s3_quad_est;
  logic        s3_corr;

  logic [15:0] wk_rem_full;
  logic [3:0]  wk_rem;
  logic [2:0]  weekday_next;
  logic [15:0] quad_rem_full;
  logic [11:0] quad_rem;
  logic [5:0]  quad_next;
  logic [10:0] qday_next;
  logic [15:0] s4_days;
  logic [2:0]  s4_weekday;
  logic [5:0]  s4_quad;
  logic [10:0] s4_qday;
  logic        s4_corr;

  logic [1:0]  yq;
  logic [8:0]  doym_next;
  logic [7:0]  year_next;
  logic        in_2100;
  logic [8:0]  doy_next;
  logic [15:0] s5_days;
  logic [2:0]  s5_weekday;
  logic [7:0]  s5_year;
  logic [8:0]  s5_doym;
  logic [8:0]  s5_doy;
  logic        s5_leap;

  logic [3:0]  mon_next;
  logic [15:0] s6_days;
  logic [2:0]  s6_weekday;
  logic [7:0]  s6_year;
  logic [8:0]  s6_doym;
  logic [8:0]  s6_doy;
  logic        s6_leap;
  logic [3:0]  s6_mon;

  logic [8:0]  dom_off;

  // Stage 3: weekday and four-year block estimates.
  assign corr      = days >= DAY_MAR_2100;
  assign shifted   = days + 16'(QUAD_ORIGIN_SHIFT) + 16'(corr);
  assign wk        = days + 16'(WEEKDAY_AT_ORIGIN);
  assign wk_prod   = 32'(wk) * 32'(WEEK_RECIP);
  assign quad_prod = 32'(shifted) * 32'(QUAD_RECIP);

  always_ff @(posedge clk) begin
    if (ctrl.load[2]) begin
      s3_days     <= days;
      s3_wk       <= wk;
      s3_wk_est   <= wk_prod[31:19];
      s3_shift    <= shifted;
      s3_quad_est <= quad_prod[31:26];
      s3_corr     <= corr;
    end
  end

  // Stage 4: weekday and block corrections.
  assign wk_rem_full   = s3_wk - 16'(s3_wk_est) * 16'(DAYS_PER_WEEK);
  assign wk_rem        = wk_rem_full[3:0];
  assign quad_rem_full = s3_shift - 16'(s3_quad_est) * 16'(DAYS_PER_QUAD);
  assign quad_rem      = quad_rem_full[11:0];

  always_comb begin
    if (wk_rem >= 4'(DAYS_PER_WEEK)) begin
      weekday_next = 3'(wk_rem - 4'(DAYS_PER_WEEK)) + 3'd1;
    end else begin
      weekday_next = wk_rem[2:0] + 3'd1;
    end
    if (quad_rem >= 12'(DAYS_PER_QUAD)) begin
      quad_next = s3_quad_est + 6'd1;
      qday_next = 11'(quad_rem - 12'(DAYS_PER_QUAD));
    end else begin
      quad_next = s3_quad_est;
      qday_next = quad_rem[10:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[3]) begin
      s4_days    <= s3_days;
      s4_weekday <= weekday_next;
      s4_quad    <= quad_next;
      s4_qday    <= qday_next;
      s4_corr    <= s3_corr;
    end
  end

  // Stage 5: year within the block and day of year.
  always_comb begin
    if (s4_qday < 11'(DAYS_LEAP_YEAR)) begin
      yq        = 2'd0;
      doym_next = s4_qday[8:0];
    end else if (s4_qday < 11'(DAYS_LEAP_YEAR) + 11'(DAYS_YEAR)) begin
      yq        = 2'd1;
      doym_next = 9'(s4_qday - 11'(DAYS_LEAP_YEAR));
    end else if (s4_qday < 11'(DAYS_LEAP_YEAR) + 11'(DAYS_YEAR) + 11'(DAYS_YEAR)) begin
      yq        = 2'd2;
      doym_next = 9'(s4_qday - 11'(DAYS_LEAP_YEAR) - 11'(DAYS_YEAR));
    end else begin
      yq        = 2'd3;
      doym_next = 9'(s4_qday - 11'(DAYS_LEAP_YEAR) - 11'(DAYS_YEAR) - 11'(DAYS_YEAR));
    end
  end

  assign year_next = {s4_quad, yq} - QUAD_YEAR_BIAS;
  assign in_2100   = (s4_quad == QUAD_2100) && (yq == 2'd0);
  assign doy_next  = doym_next - 9'(in_2100 && s4_corr);

  always_ff @(posedge clk) begin
    if (ctrl.load[4]) begin
      s5_days    <= s4_days;
      s5_weekday <= s4_weekday;
      s5_year    <= year_next;
      s5_doym    <= doym_next;
      s5_doy     <= doy_next;
      s5_leap    <= (yq == 2'd0);
    end
  end

  // Stage 6: month index by comparison with each month start.
  always_comb begin
    mon_next = 4'd0;
    for (int m = 1; m < 12; m++) begin
      if (s5_doym >= month_start(4'(m), s5_leap)) begin
        mon_next = mon_next + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[5]) begin
      s6_days    <= s5_days;
      s6_weekday <= s5_weekday;
      s6_year    <= s5_year;
      s6_doym    <= s5_doym;
      s6_doy     <= s5_doy;
      s6_leap    <= s5_leap;
      s6_mon     <= mon_next;
    end
  end

  // Stage 7: day of month and output register.
  assign dom_off = s6_doym - month_start(s6_mon, s6_leap);

  always_ff @(posedge clk) begin
    if (ctrl.load[6]) begin
      days_since_1970 <= s6_days;
      weekday         <= s6_weekday;
      year_from_2000  <= $signed(s6_year);
      day_in_year     <= s6_doy;
      month           <= s6_mon + 4'd1;
      day_in_month    <= dom_off[4:0] + 5'd1;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/epoch_to_calendar_breakdown_top.sv =====
// ============================================================================
// Epoch to calendar breakdown: top level
// Converts a Unix epoch in seconds into broken-down Gregorian date and time.
// ============================================================================
// Throughput: one transaction per cycle while out_stall is low; a bubble
// anywhere in the seven register stages is filled while the output is
// stalled.
// Reset clears all stage valid bits and sets min_valid_epoch to 1577836800;
// the block accepts input in the first cycle after reset.
`default_nettype none

module epoch_to_calendar_breakdown_top (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [ectc_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [31:0]                  pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [31:0]                  epoch_seconds,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [5:0]                        second,
  output logic [5:0]                        minute,
  output logic [4:0]                        hour,
  output logic [15:0]                       days_since_1970,
  output logic [2:0]                        weekday,
  output logic signed [7:0]                 year_from_2000,
  output logic [8:0]                        day_in_year,
  output logic [3:0]                        month,
  output logic [4:0]                        day_in_month,
  output logic                              valid_res
);
  import ectc_pkg::*;

  ectc_ctrl_t  ctrl;
  logic [31:0] min_valid_epoch;
  logic        reg_hit;
  logic [15:0] days;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[ADDR_W-1:2] == REG_MIN_VALID_EPOCH);

  always_ff @(posedge clk) begin
    if (rst) begin
      min_valid_epoch <= MIN_VALID_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      min_valid_epoch <= pwdata;
    end
  end

  assign prdata = reg_hit ? min_valid_epoch : 32'd0;

  ectc_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctrl      (ctrl)
  );

  ectc_tod u_tod (
    .clk             (clk),
    .ctrl            (ctrl),
    .epoch_seconds   (epoch_seconds),
    .min_valid_epoch (min_valid_epoch),
    .days            (days),
    .second          (second),
    .minute          (minute),
    .hour            (hour),
    .valid_res       (valid_res)
  );

  ectc_date u_date (
    .clk             (clk),
    .ctrl            (ctrl),
    .days            (days),
    .days_since_1970 (days_since_1970),
    .weekday         (weekday),
    .year_from_2000  (year_from_2000),
    .day_in_year     (day_in_year),
    .month           (month),
    .day_in_month    (day_in_month)
  );

endmodule

`default_nettype wire

// ===== rtl/ectc_checker.sv =====
// ============================================================================
// Epoch to calendar breakdown: port checker
// Checks result ranges, stall behaviour and reset on the top-level ports.
// ============================================================================
`default_nettype none
`include "epoch_to_calendar_breakdown_top_defines.svh"

module ectc_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic [5:0]        second,
  input wire logic [5:0]        minute,
  input wire logic [4:0]        hour,
  input wire logic [15:0]       days_since_1970,
  input wire logic [2:0]        weekday,
  input wire logic signed [7:0] year_from_2000,
  input wire logic [8:0]        day_in_year,
  input wire logic [3:0]        month,
  input wire logic [4:0]        day_in_month,
  input wire logic              valid_res
);

  `ECTC_ASSERT_NEXT(a_stalled_result_holds, clk, rst, out_valid && out_stall,
    out_valid && $stable(days_since_1970) && $stable(second) && $stable(day_in_month)
    && $stable(valid_res), "A stalled result transaction changed.")

  `ECTC_ASSERT_NOW(a_time_in_range, clk, rst, out_valid,
    (second < 6'd60) && (minute < 6'd60) && (hour < 5'd24) && (weekday != 3'd0),
    "A time field of a result lies outside its range.")

  `ECTC_ASSERT_NOW(a_date_in_range, clk, rst, out_valid,
    (month >= 4'd1) && (month <= 4'd12) && (day_in_month != 5'd0)
    && (day_in_year <= 9'd365) && (year_from_2000 >= -8'sd30)
    && (year_from_2000 <= 8'sd106), "A date field of a result lies outside its range.")

  `ECTC_ASSERT_NOW(a_reset_empties, clk, rst, $past(rst), !out_valid,
    "A result was offered straight after reset.")

endmodule

bind epoch_to_calendar_breakdown_top ectc_checker u_ectc_checker (.*);

`default_nettype wire

// ===== sim/epoch_to_calendar_breakdown_top_tb.sv =====
// ============================================================================
// Epoch to calendar breakdown: testbench
// Sends epochs through the converter under random input gaps and output
// stalls, and checks every result against a typed or bench-computed calendar.
// The run steps through several min_valid_epoch settings, extremes included.
// ============================================================================

module epoch_to_calendar_breakdown_top_tb;

  import ectc_pkg::*;

  typedef struct packed {
    logic [5:0]        second;
    logic [5:0]        minute;
    logic [4:0]        hour;
    logic [15:0]       days;
    logic [2:0]        weekday;
    logic signed [7:0] year;
    logic [8:0]        yday;
    logic [3:0]        month;
    logic [4:0]        mday;
    logic              valid;
  } calendar_t;

  typedef struct packed {
    logic [31:0] epoch;
    logic        typed;
    calendar_t   want;
  } directed_row_t;

  localparam logic [ADDR_W-1:0] THRESHOLD_ADDR = {REG_MIN_VALID_EPOCH, 2'b00};
  localparam int NUM_PHASES       = 5;
  localparam int RANDOM_PER_PHASE = 256;
  localparam int LONG_HOLD        = 80;
  localparam int DRAIN_CYCLES     = 20;
  localparam int MONTH_DAYS [12]  = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
  localparam int DIRECTED_N       = 21;

  localparam directed_row_t DIRECTED_ROWS [DIRECTED_N] = '{
    '{32'd0,          1'b1, '{6'd0, 6'd0, 5'd0, 16'd0, 3'd5, -8'sd30, 9'd0, 4'd1, 5'd1, 1'b0}},
    '{32'hFFFFFFFF,   1'b1,
      '{6'd15, 6'd28, 5'd6, 16'd49710, 3'd1, 8'sd106, 9'd37, 4'd2, 5'd7, 1'b1}},
    '{32'd1577836800, 1'b1,
      '{6'd0, 6'd0, 5'd0, 16'd18262, 3'd4, 8'sd20, 9'd0, 4'd1, 5'd1, 1'b0}},
    '{32'd1577836801, 1'b1,
      '{6'd1, 6'd0, 5'd0, 16'd18262, 3'd4, 8'sd20, 9'd0, 4'd1, 5'd1, 1'b1}},
    '{32'd1577836799, 1'b1,
      '{6'd59, 6'd59, 5'd23, 16'd18261, 3'd3, 8'sd19, 9'd364, 4'd12, 5'd31, 1'b0}},
    '{32'd86399,      1'b1, '{6'd59, 6'd59, 5'd23, 16'd0, 3'd5, -8'sd30, 9'd0, 4'd1, 5'd1, 1'b0}},
    '{32'd86400,      1'b1, '{6'd0, 6'd0, 5'd0, 16'd1, 3'd6, -8'sd30, 9'd1, 4'd1, 5'd2, 1'b0}},
    '{32'd31449600,   1'b0, '0},
    '{32'd68169599,   1'b0, '0},
    '{32'd68169600,   1'b0, '0},
    '{32'd68256000,   1'b0, '0},
    '{32'd94694399,   1'b0, '0},
    '{32'd94694400,   1'b0, '0},
    '{32'd946684799,  1'b0, '0},
    '{32'd951825600,  1'b0, '0},
    '{32'd978307199,  1'b0, '0},
    '{32'd2147483647, 1'b0, '0},
    '{32'd2147483648, 1'b0, '0},
    '{32'd4107542399, 1'b0, '0},
    '{32'd4107542400, 1'b0, '0},
    '{32'd4133980799, 1'b0, '0}
  };

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [ADDR_W-1:0]       paddr = '0;
  logic [31:0]             pwdata = '0;
  logic [31:0]             prdata;
  logic                    pready;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [31:0]             epoch_seconds = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [5:0]              second;
  logic [5:0]              minute;
  logic [4:0]              hour;
  logic [15:0]             days_since_1970;
  logic [2:0]              weekday;
  logic signed [7:0]       year_from_2000;
  logic [8:0]              day_in_year;
  logic [3:0]              month;
  logic [4:0]              day_in_month;
  logic                    valid_res;

  calendar_t   pending_dates [$];
  logic [31:0] valid_threshold = MIN_VALID_RESET;
  int          epochs_sent = 0;
  int          dates_checked = 0;
  int          mismatches = 0;
  int          settings_used = 1;
  int          tx_gap_pct = 0;
  int          rx_stall_pct = 0;
  bit          quiet = 1'b0;
  bit          hold_request = 1'b0;

  epoch_to_calendar_breakdown_top dut (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .epoch_seconds   (epoch_seconds),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .second          (second),
    .minute          (minute),
    .hour            (hour),
    .days_since_1970 (days_since_1970),
    .weekday         (weekday),
    .year_from_2000  (year_from_2000),
    .day_in_year     (day_in_year),
    .month           (month),
    .day_in_month    (day_in_month),
    .valid_res       (valid_res)
  );

  initial begin
    forever begin
      #4 clk = ~clk;
    end
  end

  initial begin
    #4000000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic bit is_leap_year(input int unsigned y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic calendar_t convert_epoch(input logic [31:0] e, input logic [31:0] thr);
    calendar_t   c;
    int unsigned t;
    int unsigned days;
    int unsigned rest;
    int unsigned y;
    int unsigned len;
    int          m;
    t = e / 60;
    c.second = 6'(e % 60);
    c.minute = 6'(t % 60);
    t = t / 60;
    c.hour = 5'(t % 24);
    days = t / 24;
    c.days = 16'(days);
    c.weekday = 3'((days + 4) % 7 + 1);
    y = 1970;
    rest = days;
    while (rest >= (is_leap_year(y) ? 366 : 365)) begin
      rest = rest - (is_leap_year(y) ? 366 : 365);
      y++;
    end
    c.year = 8'(y - 2000);
    c.yday = 9'(rest);
    for (m = 0; m < 11; m++) begin
      len = (m == 1 && is_leap_year(y)) ? 29 : MONTH_DAYS[m];
      if (rest < len) break;
      rest = rest - len;
    end
    c.month = 4'(m + 1);
    c.mday = 5'(rest + 1);
    c.valid = e > thr;
    return c;
  endfunction

  // Each random epoch is either uniform or placed on month and year
  // boundaries, around the threshold, at the ends of the range or near 2100.
  function automatic logic [31:0] random_epoch(input logic [31:0] thr);
    calendar_t    c;
    int           d;
    longint       e64;
    logic [31:0]  e;
    case ($urandom_range(0, 9))
      4, 5, 6: begin
        d = $urandom_range(0, 49710);
        c = convert_epoch(32'(longint'(d) * 86400), thr);
        d = d - int'(c.mday) + 1 - int'($urandom_range(0, 1));
        if (d < 0) d = 0;
        case ($urandom_range(0, 2))
          0:       e64 = longint'(d) * 86400;
          1:       e64 = longint'(d) * 86400 + 86399;
          default: e64 = longint'(d) * 86400 + $urandom_range(0, 86399);
        endcase
        if (e64 > 64'hFFFFFFFF) e64 = 64'hFFFFFFFF;
        e = 32'(e64);
      end
      7: e = thr + 32'($urandom_range(0, 6)) - 32'd3;
      8: e = $urandom_range(0, 1) ? 32'($urandom_range(0, 200))
                                  : 32'hFFFFFFFF - 32'($urandom_range(0, 200));
      9: e = 32'(longint'($urandom_range(47400, 47710)) * 86400 + $urandom_range(0, 86399));
      default: e = $urandom;
    endcase
    return e;
  endfunction

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  task automatic offer_epoch(input logic [31:0] e, input calendar_t want);
    if (!quiet && tx_gap_pct != 0 && $urandom_range(1, 100) <= tx_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid <= 1'b1;
    epoch_seconds <= e;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    pending_dates.push_back(want);
    epochs_sent++;
  endtask

  task automatic write_threshold(input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= THRESHOLD_ADDR;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    valid_threshold = value;
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    check_field("min_valid_epoch", longint'(value), longint'(prdata));
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Each completed output transaction is compared at the falling edge before
  // the rising edge that takes it.
  always @(negedge clk) begin
    calendar_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_dates.size() == 0) begin
        $error("result transaction arrived with none outstanding");
        mismatches++;
      end else begin
        want = pending_dates.pop_front();
        dates_checked++;
        check_field("second", want.second, second);
        check_field("minute", want.minute, minute);
        check_field("hour", want.hour, hour);
        check_field("days_since_1970", want.days, days_since_1970);
        check_field("weekday", want.weekday, weekday);
        check_field("year_from_2000", longint'($signed(want.year)),
                    longint'(year_from_2000));
        check_field("day_in_year", want.yday, day_in_year);
        check_field("month", want.month, month);
        check_field("day_in_month", want.mday, day_in_month);
        check_field("valid_res", want.valid, valid_res);
      end
    end
  end

  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!quiet && rx_stall_pct != 0 && $urandom_range(1, 100) <= rx_stall_pct) begin
        n = $urandom_range(1, 15);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    logic [31:0] thresholds [NUM_PHASES];
    calendar_t   want;
    logic [31:0] next_epoch;
    int          phase;
    int          k;
    thresholds[0] = MIN_VALID_RESET;
    thresholds[1] = 32'd0;
    thresholds[2] = 32'hFFFFFFFF;
    thresholds[3] = $urandom;
    thresholds[4] = $urandom;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0:       begin tx_gap_pct = 20; rx_stall_pct = 20; end
        1:       begin tx_gap_pct = 0;  rx_stall_pct = 0;  end
        2:       begin tx_gap_pct = 40; rx_stall_pct = 10; end
        3:       begin tx_gap_pct = 10; rx_stall_pct = 40; end
        default: quiet = 1'b1;
      endcase
      if (phase == 0) begin
        for (k = 0; k < DIRECTED_N; k++) begin
          want = DIRECTED_ROWS[k].typed ? DIRECTED_ROWS[k].want
                                        : convert_epoch(DIRECTED_ROWS[k].epoch, valid_threshold);
          offer_epoch(DIRECTED_ROWS[k].epoch, want);
        end
      end else begin
        write_threshold(thresholds[phase]);
        settings_used++;
      end
      for (k = 0; k < RANDOM_PER_PHASE; k++) begin
        if (phase == 1 && k == 40) hold_request = 1'b1;
        next_epoch = random_epoch(valid_threshold);
        offer_epoch(next_epoch, convert_epoch(next_epoch, valid_threshold));
      end
      in_valid <= 1'b0;
      while (pending_dates.size() != 0) @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Converted %0d epochs under %0d threshold settings, %0d results compared.",
             epochs_sent, settings_used, dates_checked);
    $display("Covered range ends, leap days, century years and threshold edges.");
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== epoch_to_calendar_breakdown_top.f =====
+incdir+rtl
rtl/ectc_pkg.sv
rtl/ectc_pipe_ctrl.sv
rtl/ectc_tod.sv
rtl/ectc_date.sv
rtl/epoch_to_calendar_breakdown_top.sv
rtl/ectc_checker.sv
sim/epoch_to_calendar_breakdown_top_tb.sv
